FILE: hdl/sha256_stream_hasher_assert.svh
// assertion macros for the sha-256 stream hasher
// included by the modules that check their own control logic
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH
`ifndef ASSERT_OFF
`define SHA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SHA_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SHA_ASSERT_IMP(label, clk, rst, ante, cons)
`define SHA_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/sha256_pkg.sv
// types, constants and round functions for the sha-256 stream hasher
// no dependencies
package sha256_pkg;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        last;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BYTE,
    ST_PAD,
    ST_LOAD_RD,
    ST_LOAD,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } state_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;

  localparam logic [31:0] HASH_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] ror(input logic [31:0] v, input int n);
    ror = (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] v);
    sig0 = ror(v, 7) ^ ror(v, 18) ^ (v >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] v);
    sig1 = ror(v, 17) ^ ror(v, 19) ^ (v >> 10);
  endfunction

endpackage

FILE: hdl/sha256_stream_hasher.sv
// sha-256 stream hasher: byte packing, padding, 64-round compression
// data beat registered, then bytes stored; block: load-read, load, rounds, final
// last beat: pad bytes one per cycle up to byte 63, one or two blocks, 8 digest beats
// throughput: one round per cycle, one byte per cycle into the block buffer memory
// reset: synchronous; chain value back to initial hash, fill, length and flags cleared
// uses sha256_pkg and sha256_stream_hasher_assert.svh
`include "sha256_stream_hasher_assert.svh"
module sha256_stream_hasher (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sha256_pkg::in_beat_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sha256_pkg::out_beat_t out_data
);
  import sha256_pkg::*;

  // block buffer: 16 words, byte-enable writes, registered read
  logic [31:0] wmem [16];
  logic [3:0]  wm_addr;
  logic [3:0]  wm_be;
  logic [31:0] wm_wdata;
  logic        wm_we;
  logic [3:0]  wm_raddr;
  logic [31:0] wm_rdata;

  always_ff @(posedge clk) begin
    if (wm_we) begin
      for (int k = 0; k < 4; k++) begin
        if (wm_be[k]) wmem[wm_addr][k*8 +: 8] <= wm_wdata[k*8 +: 8];
      end
    end
    wm_rdata <= wmem[wm_raddr];
  end

  state_t      state, state_next;
  logic [31:0] word_r;
  logic [2:0]  nbytes;
  logic [1:0]  bidx;
  logic        last_r;
  logic [5:0]  fill;
  logic [63:0] msg_len;
  logic        final_blk;
  logic [6:0]  t;
  logic [31:0] win [16];
  logic [31:0] hv [8];
  logic [31:0] a, b, c, d, e, f, g, h;
  logic [2:0]  oidx;

  logic [7:0]  cur_byte;
  logic [31:0] w_t, t1, t2, s0, s1, ch, mj;
  logic [63:0] bits;

  assign bits = {msg_len[60:0], 3'b000};
  assign cur_byte = word_r[31 - 8*bidx -: 8];

  always_comb begin
    w_t = (t < 7'd16) ? wm_rdata :
      win[0] + sig0(win[1]) + win[9] + sig1(win[14]);
  end
  assign s1 = ror(e, 6) ^ ror(e, 11) ^ ror(e, 25);
  assign ch = (e & f) ^ (~e & g);
  assign s0 = ror(a, 2) ^ ror(a, 13) ^ ror(a, 22);
  assign mj = (a & b) ^ (a & c) ^ (b & c);
  assign t1 = h + s1 + ch + ROUND_K[t[5:0]] + w_t;
  assign t2 = s0 + mj;

  // pad phase: byte 0x80 at fill, then zeros, length in last two words
  logic [5:0] pad_pos;
  logic       pad_first;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_BYTE;
      ST_BYTE: begin
        if (nbytes != 3'd0 && fill == 6'd63) state_next = ST_LOAD_RD;
        else if (nbytes == 3'd0 || nbytes == 3'd1)
          state_next = last_r ? ST_PAD : ST_IDLE;
      end
      ST_PAD: begin
        if (pad_pos == 6'd63) state_next = ST_LOAD_RD;
      end
      ST_LOAD_RD: state_next = ST_LOAD;
      ST_LOAD:    state_next = ST_ROUND;
      ST_ROUND:   if (t == 7'd63) state_next = ST_FINAL;
      ST_FINAL: begin
        if (final_blk) state_next = ST_EMIT;
        else if (nbytes != 3'd0) state_next = ST_BYTE;
        else if (last_r && !pad_first) state_next = ST_PAD;
        else if (last_r) state_next = ST_PAD;
        else state_next = ST_IDLE;
      end
      ST_EMIT: if (!out_stall && oidx == 3'd7) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    wm_we = 1'b0;
    wm_addr = fill[5:2];
    wm_be = 4'b0000;
    wm_wdata = {4{cur_byte}};
    wm_raddr = t[3:0] + 4'd1;
    in_stall = (state != ST_IDLE);
    out_valid = (state == ST_EMIT);
    out_data.digest_word = hv[oidx];
    out_data.word_index = oidx;
    out_data.last_word = (oidx == 3'd7);
    unique case (state)
      ST_BYTE: begin
        wm_we = (nbytes != 3'd0);
        wm_be = 4'b1000 >> fill[1:0];
      end
      ST_PAD: begin
        wm_we = 1'b1;
        wm_addr = pad_pos[5:2];
        wm_be = 4'b1000 >> pad_pos[1:0];
        if (pad_first) wm_wdata = {4{PAD_BYTE}};
        else if (final_blk && pad_pos >= LEN_POS)
          wm_wdata = {4{bits[63 - 8*(pad_pos - LEN_POS) -: 8]}};
        else wm_wdata = 32'h0;
      end
      ST_LOAD_RD: wm_raddr = 4'd0;
      ST_LOAD:    wm_raddr = 4'd0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill <= '0;
      msg_len <= '0;
      final_blk <= 1'b0;
      pad_first <= 1'b0;
      oidx <= '0;
      for (int i = 0; i < 8; i++) hv[i] <= HASH_INIT[i];
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: if (in_valid) begin
          word_r <= in_data.data_word;
          nbytes <= (in_data.valid_bytes > 3'd4) ? 3'd4 : in_data.valid_bytes;
          last_r <= in_data.last;
          bidx <= 2'd0;
          pad_first <= 1'b1;
        end
        ST_BYTE: begin
          if (nbytes != 3'd0) begin
            fill <= fill + 6'd1;
            msg_len <= msg_len + 64'd1;
            nbytes <= nbytes - 3'd1;
            bidx <= bidx + 2'd1;
          end
          pad_pos <= fill + ((nbytes != 3'd0) ? 6'd1 : 6'd0);
        end
        ST_PAD: begin
          if (pad_first) begin
            pad_first <= 1'b0;
            if (pad_pos < LEN_POS) final_blk <= 1'b1;
          end
          pad_pos <= pad_pos + 6'd1;
        end
        ST_LOAD_RD: begin
          t <= '0;
          fill <= '0;
        end
        ST_LOAD: begin
          {a, b, c, d, e, f, g, h} <=
            {hv[0], hv[1], hv[2], hv[3], hv[4], hv[5], hv[6], hv[7]};
        end
        ST_ROUND: begin
          for (int i = 0; i < 15; i++) win[i] <= win[i+1];
          win[15] <= w_t;
          {b, c, d} <= {a, b, c};
          {f, g, h} <= {e, f, g};
          a <= t1 + t2;
          e <= d + t1;
          t <= t + 7'd1;
        end
        ST_FINAL: begin
          hv[0] <= hv[0] + a; hv[1] <= hv[1] + b;
          hv[2] <= hv[2] + c; hv[3] <= hv[3] + d;
          hv[4] <= hv[4] + e; hv[5] <= hv[5] + f;
          hv[6] <= hv[6] + g; hv[7] <= hv[7] + h;
          pad_pos <= '0;
          oidx <= '0;
          // extra pad block carries the length
          if (!final_blk && last_r && nbytes == 3'd0 && !pad_first) final_blk <= 1'b1;
        end
        ST_EMIT: if (!out_stall) begin
          oidx <= oidx + 3'd1;
          if (oidx == 3'd7) begin
            for (int i = 0; i < 8; i++) hv[i] <= HASH_INIT[i];
            fill <= '0;
            msg_len <= '0;
            final_blk <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  `SHA_ASSERT_IMP(a_emit_only, clk, rst, out_valid, state == ST_EMIT && final_blk)
  `SHA_ASSERT_IMP(a_no_in_busy, clk, rst, state != ST_IDLE, in_stall)
  `SHA_ASSERT_NXT(a_round_step, clk, rst, state == ST_ROUND && t != 7'd63, state == ST_ROUND)
  `SHA_ASSERT_NXT(a_emit_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))
endmodule

FILE: test/tb_sha256_stream_hasher.sv
// self-checking testbench for the sha-256 stream hasher
// drives byte-packed message beats, predicts digests with its own sha-256 model
// depends on sha256_pkg and the sha256_stream_hasher rtl
`timescale 1ns / 1ps
module tb_sha256_stream_hasher;
  import sha256_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TOTAL_ITEMS = 260;
  localparam int HOLD_OFF_CYCLES = 400;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_beat_t in_data;
  logic out_valid;
  logic out_stall;
  out_beat_t out_data;
  logic in_fire;

  sha256_stream_hasher i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // predictor state
  logic [31:0] hash_state [8];
  logic [7:0]  msg_block [64];
  int unsigned block_fill;
  logic [63:0] msg_bytes;

  in_beat_t  beat_queue [$];
  out_beat_t digest_queue [$];

  int mismatches = 0;
  int digests_seen = 0;
  int messages_sent = 0;
  int items_queued = 0;
  int idle_cycles = 0;
  bit timed_out = 0;
  bit quiet_phase = 0;
  bit hold_off_req = 0;
  bit hold_off_taken = 0;
  int hold_off_len = 0;
  int gap_left = 0;
  int stall_left = 0;

  function automatic logic [31:0] rot_r(logic [31:0] v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic hash_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = rot_r(w[i-15], 7) ^ rot_r(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rot_r(w[i-2], 17) ^ rot_r(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
    for (int t = 0; t < 64; t++) begin
      s1 = rot_r(e, 6) ^ rot_r(e, 11) ^ rot_r(e, 25);
      t1 = h + s1 + ((e & f) ^ (~e & g)) + ROUND_K[t] + w[t];
      s0 = rot_r(a, 2) ^ rot_r(a, 13) ^ rot_r(a, 22);
      t2 = s0 + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endtask

  task automatic append_byte(logic [7:0] v);
    msg_block[block_fill] = v;
    block_fill++;
    msg_bytes++;
    if (block_fill == 64) begin
      hash_block();
      block_fill = 0;
    end
  endtask

  task automatic restart_message();
    for (int i = 0; i < 8; i++) hash_state[i] = HASH_INIT[i];
    block_fill = 0;
    msg_bytes = '0;
  endtask

  task automatic predict_digest(in_beat_t bt);
    int unsigned n;
    logic [63:0] bit_len;
    out_beat_t ob;
    n = (bt.valid_bytes > 4) ? 4 : bt.valid_bytes;
    for (int i = 0; i < n; i++) append_byte(bt.data_word[31-8*i -: 8]);
    if (!bt.last) return;
    bit_len = msg_bytes << 3;
    msg_block[block_fill] = PAD_BYTE;
    block_fill++;
    if (block_fill > 56) begin
      for (int i = block_fill; i < 64; i++) msg_block[i] = '0;
      hash_block();
      block_fill = 0;
    end
    for (int i = block_fill; i < 56; i++) msg_block[i] = '0;
    for (int i = 0; i < 8; i++) msg_block[63-i] = bit_len[8*i +: 8];
    hash_block();
    for (int i = 0; i < 8; i++) begin
      ob.digest_word = hash_state[i];
      ob.word_index = i[2:0];
      ob.last_word = (i == 7);
      digest_queue.push_back(ob);
    end
    restart_message();
  endtask

  function automatic in_beat_t make_beat(logic [31:0] d, logic [2:0] n, logic l);
    in_beat_t bt;
    bt.data_word = d;
    bt.valid_bytes = n;
    bt.last = l;
    return bt;
  endfunction

  task automatic push_beat(in_beat_t bt);
    beat_queue.push_back(bt);
    items_queued++;
  endtask

  // queue a message of nbytes with random content, in full words then a tail
  task automatic queue_message(int nbytes);
    int left;
    left = nbytes;
    while (left > 4) begin
      push_beat(make_beat($urandom, 3'd4, 1'b0));
      left -= 4;
    end
    push_beat(make_beat($urandom, left[2:0], 1'b1));
    messages_sent++;
  endtask

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst = 1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;
  end

  // accepted-input tracking at posedge
  always @(posedge clk) begin
    in_fire = !rst && in_valid && !in_stall;
  end

  // driver: next beat on the falling edge once the current one is taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else if (in_valid && !in_fire) begin
      // stalled beat keeps its payload
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (beat_queue.size() > 0) begin
      in_valid <= 1'b1;
      in_data <= beat_queue.pop_front();
      if (!quiet_phase && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 10);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // predictor update on acceptance
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) predict_digest(in_data);
  end

  // receiver stall
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_off_len > 0) begin
      hold_off_len--;
      out_stall <= 1'b1;
    end else if (hold_off_req && !hold_off_taken) begin
      hold_off_taken = 1'b1;
      hold_off_len = HOLD_OFF_CYCLES;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    out_beat_t exp_beat;
    if (!rst && out_valid && !out_stall) begin
      digests_seen++;
      if (digest_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected digest beat %h idx %0d", out_data.digest_word,
                   out_data.word_index);
      end else begin
        exp_beat = digest_queue.pop_front();
        if (out_data !== exp_beat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
                     exp_beat.digest_word, exp_beat.word_index, exp_beat.last_word,
                     out_data.digest_word, out_data.word_index, out_data.last_word);
        end
      end
    end
  end

  // watchdog on cycles with no beat accepted on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("tb_sha256_stream_hasher failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (beat_queue.size() > 0 || in_valid || digest_queue.size() > 0) @(posedge clk);
  endtask

  initial begin
    int nb;
    restart_message();
    @(negedge rst);

    // directed: empty message, short messages, extremes, oversize counts, block-boundary lengths
    push_beat(make_beat(32'h0, 3'd0, 1'b1));
    push_beat(make_beat(32'h61626300, 3'd3, 1'b1));
    push_beat(make_beat(32'hffffffff, 3'd4, 1'b0));
    push_beat(make_beat(32'hdeadbeef, 3'd0, 1'b0));
    push_beat(make_beat(32'h00000000, 3'd7, 1'b0));
    push_beat(make_beat(32'hffffffff, 3'd5, 1'b0));
    push_beat(make_beat(32'h12345678, 3'd6, 1'b1));
    push_beat(make_beat(32'ha5a5a5a5, 3'd1, 1'b1));
    push_beat(make_beat(32'h5a5a5a5a, 3'd2, 1'b1));
    messages_sent += 5;
    queue_message(55);
    queue_message(56);
    queue_message(64);
    wait_drained();

    // long receiver hold-off with the sender busy
    hold_off_req = 1;
    queue_message(40);
    queue_message(12);
    wait_drained();

    while (items_queued < TOTAL_ITEMS - 30) begin
      nb = ($urandom_range(0, 9) == 0) ? int'($urandom_range(50, 130))
                                        : int'($urandom_range(0, 24));
      if ($urandom_range(0, 5) == 0)
        push_beat(make_beat($urandom, 3'($urandom_range(0, 7)), 1'b0));
      queue_message(nb);
      if (beat_queue.size() > 40) wait_drained();
    end
    wait_drained();

    quiet_phase = 1;
    repeat (5) queue_message(int'($urandom_range(0, 20)));
    wait_drained();
    repeat (200) @(posedge clk);

    $display("run covered %0d messages in %0d input beats, empty, oversize and multi-block",
             messages_sent, items_queued);
    $display("%0d digest beats checked under random idling and a long output hold-off",
             digests_seen);
    if (mismatches == 0 && digest_queue.size() == 0) begin
      $display("tb_sha256_stream_hasher passed");
    end else begin
      $display("tb_sha256_stream_hasher failed");
    end
    $finish;
  end
endmodule
